>>> sv/dhlt_pkg.sv
`default_nettype none
// ============================================================================
// dhlt_pkg: shared types and constants of the DH link transform
// Holds the CORDIC arctangent table, fixed-point formats and the structures
// that travel between the cell chain, the rounding stage and the matrix stage.
// ============================================================================
package dhlt_pkg;

    // Width of the CORDIC x and y datapath, 30 fraction bits plus headroom.
    localparam int unsigned XY_W = 33;
    // Width of the angle accumulator, units of 2^-32 turn plus headroom.
    localparam int unsigned Z_W = 33;
    // Number of arctangent entries available to the chain.
    localparam int unsigned ATAN_ENTRIES = 24;

    // Start value of x, which cancels the CORDIC gain.
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;

    // Rounding offset and clamp limits for the Q30 to Q16 conversion.
    localparam logic signed [XY_W-1:0] TRIG_ROUND = 33'sd8192;
    localparam logic signed [XY_W-1:0] TRIG_HI    = 33'sd65536;
    localparam logic signed [XY_W-1:0] TRIG_LO    = -33'sd65536;

    // Limits of a rotation entry with 16 fraction bits.
    localparam logic signed [17:0] ROT_MAX = 18'sd65536;
    localparam logic signed [17:0] ROT_MIN = -18'sd65536;

    // Arctangent of 2^-i in units of 2^-32 turn.
    localparam logic [30:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
        31'd536870912, 31'd316933406, 31'd167458907, 31'd85004756,
        31'd42667331,  31'd21354465,  31'd10679838,  31'd5340245,
        31'd2670163,   31'd1335087,   31'd667544,    31'd333772,
        31'd166886,    31'd83443,     31'd41722,     31'd20861,
        31'd10430,     31'd5215,      31'd2608,      31'd1304,
        31'd652,       31'd326,       31'd163,       31'd81
    };

    // One rotation in flight: vector, residual angle and fold flag.
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   flip;
    } rot_t;

    // Link lengths and convention select, carried alongside the angles.
    typedef struct packed {
        logic signed [23:0] offset;
        logic signed [23:0] length;
        logic               modified;
    } link_t;

    // Contents of one cell of the CORDIC chain.
    typedef struct packed {
        rot_t  theta;
        rot_t  alpha;
        link_t link;
    } cell_data_t;

    // Sine and cosine of both angles with 16 fraction bits.
    typedef struct packed {
        logic signed [17:0] ct;
        logic signed [17:0] st;
        logic signed [17:0] ca;
        logic signed [17:0] sa;
        link_t              link;
    } trig_t;

    // Top three rows of the homogeneous transform.
    typedef struct packed {
        logic signed [17:0] rot_00;
        logic signed [17:0] rot_01;
        logic signed [17:0] rot_02;
        logic signed [23:0] trans_x;
        logic signed [17:0] rot_10;
        logic signed [17:0] rot_11;
        logic signed [17:0] rot_12;
        logic signed [23:0] trans_y;
        logic signed [17:0] rot_20;
        logic signed [17:0] rot_21;
        logic signed [17:0] rot_22;
        logic signed [23:0] trans_z;
    } result_t;

endpackage
`default_nettype wire

>>> sv/dh_link_transform_top.sv
`default_nettype none
// ============================================================================
// dh_link_transform_top: Denavit-Hartenberg link transform engine
// Computes the top three rows of one link's homogeneous transform in the
// classic or modified convention from two angles and two lengths.
// ============================================================================
// The block accepts one link per clock cycle while the output is not held
// and returns its transform through a registered stage per CORDIC cell,
// one for rounding sine and cosine, one for the multipliers and one for
// the output register. Each CORDIC cell holds one link for one rotation
// step of both angles; every stage moves independently, so empty slots
// close up under back pressure and a new link is taken while a result
// waits at the output if any stage is empty. s_tuser carries the
// convention select: low for the classic form, high for the modified form.
module dh_link_transform_top #(
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // joint_angle[15:0], twist_angle[31:16], link_offset[55:32],
    // link_length[79:56]
    input  logic [79:0]  s_tdata,
    // modified_form
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // rot_00[17:0], rot_01[35:18], rot_02[53:36], trans_x[77:54],
    // rot_10[95:78], rot_11[113:96], rot_12[131:114], trans_y[155:132],
    // rot_20[173:156], rot_21[191:174], rot_22[209:192], trans_z[233:210],
    // zero padding[239:234]
    output logic [239:0] m_tdata
);
    import dhlt_pkg::*;

    logic       chain_valid [0:CORDIC_STEPS];
    logic       chain_ready [0:CORDIC_STEPS];
    cell_data_t chain_data  [0:CORDIC_STEPS];
    logic       trig_valid;
    logic       trig_ready;
    trig_t      trig_data;
    result_t    res;

    // Fold an angle into the right half plane and set up the CORDIC vector.
    function automatic rot_t fold(input logic signed [15:0] ang);
        rot_t             r;
        logic signed [16:0] w;
        w = 17'(ang);
        r.flip = 1'b0;
        if (w > 17'sd16384) begin
            w = w - 17'sd32768;
            r.flip = 1'b1;
        end else if (w < -17'sd16384) begin
            w = w + 17'sd32768;
            r.flip = 1'b1;
        end
        r.x = CORDIC_GAIN;
        r.y = '0;
        r.z = {{(Z_W-32){w[15]}}, w[15:0], 16'h0000};
        return r;
    endfunction

    // Head of the chain takes the input transfer directly.
    always_comb begin
        chain_data[0].theta         = fold(s_tdata[15:0]);
        chain_data[0].alpha         = fold(s_tdata[31:16]);
        chain_data[0].link.offset   = s_tdata[55:32];
        chain_data[0].link.length   = s_tdata[79:56];
        chain_data[0].link.modified = s_tuser;
    end

    assign chain_valid[0] = s_tvalid;
    assign s_tready       = chain_ready[0];

    // Row of CORDIC cells, one rotation step each.
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
        dhlt_cordic_cell #(
            .STEP(i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (chain_valid[i]),
            .in_ready (chain_ready[i]),
            .in_data  (chain_data[i]),
            .out_valid(chain_valid[i+1]),
            .out_ready(chain_ready[i+1]),
            .out_data (chain_data[i+1])
        );
    end

    dhlt_sincos_round u_round (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (chain_valid[CORDIC_STEPS]),
        .in_ready (chain_ready[CORDIC_STEPS]),
        .in_data  (chain_data[CORDIC_STEPS]),
        .out_valid(trig_valid),
        .out_ready(trig_ready),
        .out_data (trig_data)
    );

    dhlt_matrix u_matrix (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (trig_valid),
        .in_ready (trig_ready),
        .in_data  (trig_data),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (res)
    );

    // Pack the result fields, first field in the lowest bits.
    assign m_tdata = {6'b000000,
                      res.trans_z, res.rot_22, res.rot_21, res.rot_20,
                      res.trans_y, res.rot_12, res.rot_11, res.rot_10,
                      res.trans_x, res.rot_02, res.rot_01, res.rot_00};

`ifndef SYNTHESIS
    // The pipeline comes out of reset empty.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Input back pressure can only come from a result held at the output.
    a_stall_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while the output is free");

    // Rotation entries rot_00 and rot_22 stay within plus and minus one.
    a_rot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[17:0]) >= ROT_MIN
                      && $signed(m_tdata[17:0]) <= ROT_MAX
                      && $signed(m_tdata[209:192]) >= ROT_MIN
                      && $signed(m_tdata[209:192]) <= ROT_MAX))
        else $error("rotation entry out of range");
`endif

endmodule
`default_nettype wire

>>> sv/dhlt_cordic_cell.sv
`default_nettype none
// ============================================================================
// dhlt_cordic_cell: one CORDIC rotation step for both link angles
// Performs the micro-rotation of a fixed step index on the joint and twist
// vectors and hands the result to the next cell through a registered stage.
// ============================================================================
module dhlt_cordic_cell #(
    parameter int unsigned STEP = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  dhlt_pkg::cell_data_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dhlt_pkg::cell_data_t out_data
);
    import dhlt_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN_STEP = Z_W'(ATAN_TURN32[STEP]);

    logic       valid_reg;
    logic       advance;
    cell_data_t data_reg;
    cell_data_t data_next;

    // One micro-rotation, direction chosen by the sign of the residual angle.
    function automatic rot_t rotate(input rot_t r);
        rot_t                   o;
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        xs = $signed(r.x) >>> STEP;
        ys = $signed(r.y) >>> STEP;
        o.flip = r.flip;
        if (!r.z[Z_W-1]) begin
            o.x = r.x - ys;
            o.y = r.y + xs;
            o.z = r.z - ATAN_STEP;
        end else begin
            o.x = r.x + ys;
            o.y = r.y - xs;
            o.z = r.z + ATAN_STEP;
        end
        return o;
    endfunction

    // The stage moves whenever it is empty or its content is being taken.
    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    always_comb begin
        data_next.theta = rotate(in_data.theta);
        data_next.alpha = rotate(in_data.alpha);
        data_next.link  = in_data.link;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

>>> sv/dhlt_sincos_round.sv
`default_nettype none
// ============================================================================
// dhlt_sincos_round: conversion of CORDIC vectors to Q16 sine and cosine
// Rounds the Q30 vectors to 16 fraction bits, clamps them to one and undoes
// the half-turn fold, in one registered stage.
// ============================================================================
module dhlt_sincos_round (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  dhlt_pkg::cell_data_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dhlt_pkg::trig_t      out_data
);
    import dhlt_pkg::*;

    logic  valid_reg;
    logic  advance;
    trig_t data_reg;
    trig_t data_next;

    // Round to nearest with ties upward, clamp, and negate for a folded angle.
    function automatic logic signed [17:0] to_q16(input logic signed [XY_W-1:0] v,
                                                  input logic neg);
        logic signed [XY_W-1:0] r;
        logic signed [17:0]     c;
        r = (v + TRIG_ROUND) >>> 14;
        if (r > TRIG_HI) begin
            c = ROT_MAX;
        end else if (r < TRIG_LO) begin
            c = ROT_MIN;
        end else begin
            c = r[17:0];
        end
        return neg ? -c : c;
    endfunction

    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    always_comb begin
        data_next.ct   = to_q16(in_data.theta.x, in_data.theta.flip);
        data_next.st   = to_q16(in_data.theta.y, in_data.theta.flip);
        data_next.ca   = to_q16(in_data.alpha.x, in_data.alpha.flip);
        data_next.sa   = to_q16(in_data.alpha.y, in_data.alpha.flip);
        data_next.link = in_data.link;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

>>> sv/dhlt_matrix.sv
`default_nettype none
// ============================================================================
// dhlt_matrix: product and assembly stages of the link transform
// A multiplier stage forms the six products of the chosen convention, and the
// output stage rounds them, saturates computed translations and places entries.
// ============================================================================
module dhlt_matrix (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  dhlt_pkg::trig_t   in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output dhlt_pkg::result_t out_data
);
    import dhlt_pkg::*;

    // Rotation products are 18 by 18 bits, length products 24 by 18 bits.
    localparam int unsigned PP_W = 34;
    localparam int unsigned LP_W = 42;
    localparam int unsigned LR_W = 26;
    localparam logic signed [PP_W-1:0] PP_ROUND = 34'sd32768;
    localparam logic signed [LP_W-1:0] LP_ROUND = 42'sd32768;
    localparam logic signed [LR_W-1:0] TRANS_MAX = 26'sd8388607;
    localparam logic signed [LR_W-1:0] TRANS_MIN = -26'sd8388608;

    typedef struct packed {
        logic signed [PP_W-1:0] stca;
        logic signed [PP_W-1:0] stsa;
        logic signed [PP_W-1:0] ctca;
        logic signed [PP_W-1:0] ctsa;
        logic signed [LP_W-1:0] lin_c;
        logic signed [LP_W-1:0] lin_s;
        trig_t                  trig;
    } prod_t;

    logic    prod_valid_reg;
    logic    prod_advance;
    prod_t   prod_reg;
    prod_t   prod_next;
    logic    res_valid_reg;
    logic    res_advance;
    result_t res_reg;
    result_t res_next;

    // Operands of the two length products, chosen by the convention.
    logic signed [23:0] lin_len;
    logic signed [17:0] lin_cos;
    logic signed [17:0] lin_sin;

    // Rounded rotation products and length products.
    logic signed [17:0]     r_stca;
    logic signed [17:0]     r_stsa;
    logic signed [17:0]     r_ctca;
    logic signed [17:0]     r_ctsa;
    logic signed [LR_W-1:0] r_lin_c;
    logic signed [LR_W-1:0] r_lin_s;

    function automatic logic signed [17:0] rnd_rot(input logic signed [PP_W-1:0] p);
        logic signed [PP_W-1:0] r;
        r = (p + PP_ROUND) >>> 16;
        return r[17:0];
    endfunction

    function automatic logic signed [LR_W-1:0] rnd_lin(input logic signed [LP_W-1:0] p);
        logic signed [LP_W-1:0] r;
        r = (p + LP_ROUND) >>> 16;
        return r[LR_W-1:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [LR_W-1:0] v);
        logic signed [LR_W-1:0] c;
        if (v > TRANS_MAX) begin
            c = TRANS_MAX;
        end else if (v < TRANS_MIN) begin
            c = TRANS_MIN;
        end else begin
            c = v;
        end
        return c[23:0];
    endfunction

    // Multiplier stage.
    assign prod_advance = !prod_valid_reg || res_advance;
    assign in_ready     = prod_advance;

    always_comb begin
        lin_len = in_data.link.modified ? in_data.link.offset : in_data.link.length;
        lin_cos = in_data.link.modified ? in_data.ca : in_data.ct;
        lin_sin = in_data.link.modified ? in_data.sa : in_data.st;
        prod_next.stca  = PP_W'(in_data.st) * PP_W'(in_data.ca);
        prod_next.stsa  = PP_W'(in_data.st) * PP_W'(in_data.sa);
        prod_next.ctca  = PP_W'(in_data.ct) * PP_W'(in_data.ca);
        prod_next.ctsa  = PP_W'(in_data.ct) * PP_W'(in_data.sa);
        prod_next.lin_c = LP_W'(lin_len) * LP_W'(lin_cos);
        prod_next.lin_s = LP_W'(lin_len) * LP_W'(lin_sin);
        prod_next.trig  = in_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else if (prod_advance) begin
            prod_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_advance && in_valid) begin
            prod_reg <= prod_next;
        end
    end

    // Output stage: round products and place entries of the chosen convention.
    assign res_advance = !res_valid_reg || out_ready;

    always_comb begin
        r_stca  = rnd_rot(prod_reg.stca);
        r_stsa  = rnd_rot(prod_reg.stsa);
        r_ctca  = rnd_rot(prod_reg.ctca);
        r_ctsa  = rnd_rot(prod_reg.ctsa);
        r_lin_c = rnd_lin(prod_reg.lin_c);
        r_lin_s = rnd_lin(prod_reg.lin_s);
        res_next.rot_00 = prod_reg.trig.ct;
        res_next.rot_11 = r_ctca;
        res_next.rot_22 = prod_reg.trig.ca;
        if (!prod_reg.trig.link.modified) begin
            res_next.rot_01  = -r_stca;
            res_next.rot_02  = r_stsa;
            res_next.trans_x = sat24(r_lin_c);
            res_next.rot_10  = prod_reg.trig.st;
            res_next.rot_12  = -r_ctsa;
            res_next.trans_y = sat24(r_lin_s);
            res_next.rot_20  = '0;
            res_next.rot_21  = prod_reg.trig.sa;
            res_next.trans_z = prod_reg.trig.link.offset;
        end else begin
            res_next.rot_01  = -prod_reg.trig.st;
            res_next.rot_02  = '0;
            res_next.trans_x = prod_reg.trig.link.length;
            res_next.rot_10  = r_stca;
            res_next.rot_12  = -prod_reg.trig.sa;
            res_next.trans_y = sat24(-r_lin_s);
            res_next.rot_20  = r_stsa;
            res_next.rot_21  = r_ctsa;
            res_next.trans_z = sat24(r_lin_c);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (res_advance) begin
            res_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_advance && prod_valid_reg) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

endmodule
`default_nettype wire
